FILE: hdl/http_header_line_normalizer_assert.svh
// ----------------------------------------------------------------------------
// HTTP header line normalizer assertion macros
// Concurrent assertion wrappers shared by the normalizer front end and queue.
// ----------------------------------------------------------------------------
`ifndef HTTP_HEADER_LINE_NORMALIZER_ASSERT_SVH
`define HTTP_HEADER_LINE_NORMALIZER_ASSERT_SVH

`ifndef ASSERT_OFF

`define HHLN_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define HHLN_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define HHLN_ASSERT(label, clk, rst, prop, msg)

`define HHLN_ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

FILE: hdl/hhln_pkg.sv
// ----------------------------------------------------------------------------
// HTTP header line normalizer package
// Character codes, parser modes and the result plan passed front to back.
// ----------------------------------------------------------------------------
package hhln_pkg;

   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;

   localparam int HHLN_QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      MODE_COPY     = 2'd0,
      MODE_AFTER_CR = 2'd1,
      MODE_AFTER_NL = 2'd2,
      MODE_BODY     = 2'd3
   } mode_type;

   typedef struct packed {
      logic [7:0] data;
      logic       is_body;
      logic       header_end;
   } result_type;

   typedef struct packed {
      result_type first;
      result_type second;
      logic       has_second;
   } plan_type;

endpackage

FILE: hdl/http_header_line_normalizer.sv
// ----------------------------------------------------------------------------
// HTTP header line normalizer
// Folds CR/CRLF to LF and continuation lines to a space, flags the end of
// the header and passes the body through.
//
//   channel  | ports                                     | handshake
//   ---------+-------------------------------------------+--------------
//   request  | req_in_byte                               | push / full
//   response | rsp_out_byte rsp_is_body rsp_header_end   | empty / pop
//            | rsp_last_of_run                           |
//
// One request byte is taken per cycle while not full; the front end
// classifies it in the cycle it is accepted. The back end delivers one
// beat per cycle while pop is high and not empty, so a byte with two results
// holds the queue head until both are taken. full rises only when the plan
// queue holds QUEUE_DEPTH entries. Reset clears parser state and queue.
// ----------------------------------------------------------------------------
module http_header_line_normalizer
   import hhln_pkg::*;
#(
   parameter int QUEUE_DEPTH = HHLN_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_in_byte,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_is_body,
   output logic       rsp_header_end,
   output logic       rsp_last_of_run
);

   logic     accept;
   logic     plan_valid;
   plan_type plan;
   plan_type head;
   logic     q_full, q_empty, q_pop;

   assign accept = push && !q_full;
   assign full   = q_full;

   hhln_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .in_byte    (req_in_byte),
      .plan_valid (plan_valid),
      .plan       (plan)
   );

   hhln_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (plan_valid),
      .wr_data (plan),
      .rd_en   (q_pop),
      .rd_data (head),
      .q_full  (q_full),
      .q_empty (q_empty)
   );

   hhln_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .pop             (pop),
      .empty           (empty),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_is_body     (rsp_is_body),
      .rsp_header_end  (rsp_header_end),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

FILE: hdl/hhln_front.sv
// ----------------------------------------------------------------------------
// HTTP header line normalizer front end
// Classifies each input byte against the parser state and builds a plan of
// zero, one or two result beats.
// ----------------------------------------------------------------------------
`include "http_header_line_normalizer_assert.svh"

module hhln_front
   import hhln_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] in_byte,
   output logic       plan_valid,
   output plan_type   plan
);

   mode_type   mode_ff, mode_in;
   logic       lwn_ff, lwn_in;
   logic       has_plan;
   logic       is_ws;
   result_type hdr_ch, body_ch, hdr_lf, end_lf, hdr_sp;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_COPY;
         lwn_ff  <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         lwn_ff  <= lwn_in;
      end
   end

   always_comb begin
      hdr_ch  = '{data: in_byte, is_body: 1'b0, header_end: 1'b0};
      body_ch = '{data: in_byte, is_body: 1'b1, header_end: 1'b0};
      hdr_lf  = '{data: CH_LF,   is_body: 1'b0, header_end: 1'b0};
      end_lf  = '{data: CH_LF,   is_body: 1'b0, header_end: 1'b1};
      hdr_sp  = '{data: CH_SP,   is_body: 1'b0, header_end: 1'b0};
      is_ws   = (in_byte == CH_SP) || (in_byte == CH_TAB);
      mode_in  = mode_ff;
      lwn_in   = lwn_ff;
      has_plan = 1'b0;
      plan     = '{first: hdr_ch, second: hdr_ch, has_second: 1'b0};
      case (mode_ff)
         MODE_COPY: begin
            if (in_byte == CH_CR) begin
               mode_in = MODE_AFTER_CR;
            end else if (in_byte == CH_LF) begin
               if (lwn_ff) begin
                  has_plan   = 1'b1;
                  plan.first = end_lf;
                  mode_in    = MODE_BODY;
               end else begin
                  mode_in = MODE_AFTER_NL;
                  lwn_in  = 1'b1;
               end
            end else begin
               has_plan   = 1'b1;
               plan.first = hdr_ch;
               lwn_in     = 1'b0;
            end
         end
         MODE_AFTER_CR: begin
            if (lwn_ff) begin
               has_plan        = 1'b1;
               plan.first      = end_lf;
               plan.second     = body_ch;
               plan.has_second = (in_byte != CH_LF);
               mode_in         = MODE_BODY;
            end else if (in_byte == CH_LF) begin
               mode_in = MODE_AFTER_NL;
               lwn_in  = 1'b1;
            end else if (is_ws) begin
               has_plan   = 1'b1;
               plan.first = hdr_sp;
               mode_in    = MODE_COPY;
               lwn_in     = 1'b0;
            end else if (in_byte == CH_CR) begin
               has_plan   = 1'b1;
               plan.first = hdr_lf;
               mode_in    = MODE_AFTER_CR;
               lwn_in     = 1'b1;
            end else begin
               has_plan        = 1'b1;
               plan.first      = hdr_lf;
               plan.second     = hdr_ch;
               plan.has_second = 1'b1;
               mode_in         = MODE_COPY;
               lwn_in          = 1'b0;
            end
         end
         MODE_AFTER_NL: begin
            has_plan = 1'b1;
            if (is_ws) begin
               plan.first = hdr_sp;
               mode_in    = MODE_COPY;
               lwn_in     = 1'b0;
            end else begin
               plan.first = hdr_lf;
               if (in_byte == CH_CR) begin
                  mode_in = MODE_AFTER_CR;
               end else if (in_byte == CH_LF) begin
                  if (lwn_ff) begin
                     plan.second     = end_lf;
                     plan.has_second = 1'b1;
                     mode_in         = MODE_BODY;
                  end else begin
                     mode_in = MODE_AFTER_NL;
                     lwn_in  = 1'b1;
                  end
               end else begin
                  plan.second     = hdr_ch;
                  plan.has_second = 1'b1;
                  mode_in         = MODE_COPY;
                  lwn_in          = 1'b0;
               end
            end
         end
         MODE_BODY: begin
            has_plan   = 1'b1;
            plan.first = body_ch;
         end
         default: begin
            mode_in = MODE_COPY;
         end
      endcase
   end

   assign plan_valid = accept && has_plan;

   `HHLN_ASSERT(a_after_nl_lwn, clock, reset,
                (mode_ff == MODE_AFTER_NL) |-> lwn_ff,
                "held newline without newline flag")
   `HHLN_ASSERT(a_body_sticky, clock, reset,
                (mode_ff == MODE_BODY) |=> (mode_ff == MODE_BODY),
                "left body mode")
   `HHLN_ASSERT(a_end_then_body, clock, reset,
                (plan_valid && plan.first.header_end && plan.has_second) |-> plan.second.is_body,
                "byte after header end not body")

endmodule

FILE: hdl/hhln_queue.sv
// ----------------------------------------------------------------------------
// HTTP header line normalizer plan queue
// Short register queue between the front end and the back end.
// ----------------------------------------------------------------------------
`include "http_header_line_normalizer_assert.svh"

module hhln_queue
   import hhln_pkg::*;
#(
   parameter int DEPTH = HHLN_QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_en,
   input  plan_type wr_data,
   input  logic     rd_en,
   output plan_type rd_data,
   output logic     q_full,
   output logic     q_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   plan_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign rd_data = mem_ff[rd_ptr_ff];
   assign q_full  = (count_ff == CNT_W'(DEPTH));
   assign q_empty = (count_ff == '0);

   `HHLN_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH), "queue count overflow")
   `HHLN_ASSERT_NEVER(a_no_overrun, clock, reset, wr_en && q_full, "write into full queue")
   `HHLN_ASSERT_NEVER(a_no_underrun, clock, reset, rd_en && q_empty, "read from empty queue")

endmodule

FILE: hdl/hhln_back.sv
// ----------------------------------------------------------------------------
// HTTP header line normalizer back end
// Walks each queued plan and delivers its one or two result beats in order.
// ----------------------------------------------------------------------------
module hhln_back
   import hhln_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  plan_type   head,
   input  logic       q_empty,
   output logic       q_pop,
   input  logic       pop,
   output logic       empty,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_is_body,
   output logic       rsp_header_end,
   output logic       rsp_last_of_run
);

   logic       sel_second_ff, sel_second_in;
   logic       fire;
   result_type cur;

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_second_ff <= 1'b0;
      end else begin
         sel_second_ff <= sel_second_in;
      end
   end

   always_comb begin
      fire          = pop && !q_empty;
      sel_second_in = sel_second_ff;
      q_pop         = 1'b0;
      if (fire) begin
         if (head.has_second && !sel_second_ff) begin
            sel_second_in = 1'b1;
         end else begin
            sel_second_in = 1'b0;
            q_pop         = 1'b1;
         end
      end
   end

   assign cur             = sel_second_ff ? head.second : head.first;
   assign empty           = q_empty;
   assign rsp_out_byte    = cur.data;
   assign rsp_is_body     = cur.is_body;
   assign rsp_header_end  = cur.header_end;
   assign rsp_last_of_run = sel_second_ff || !head.has_second;

endmodule

FILE: tb/http_header_line_normalizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP header line normalizer testbench
// Feeds one request stream byte by byte: a directed header, a long random
// header built from lines, CRs, LFs and folds, the end of the header and a
// random body. Every result beat is compared with a behavioral model of the
// parser kept in lockstep with the accepted bytes. Both sides idle at random,
// the receiver holds off once long enough to back up the block, and the
// sender once pauses with a newline held until all results have drained.
// ----------------------------------------------------------------------------
module http_header_line_normalizer_tb
   import hhln_pkg::*;
;

   localparam int HEADER_ITEMS = 560;
   localparam int BODY_ITEMS   = 320;
   localparam int STALL_LIMIT  = 2000;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_body;
      logic       header_end;
      logic       last_of_run;
   } beat_type;

   typedef struct packed {
      mode_type mode;
      logic     after_newline;
   } parse_state_type;

   typedef struct {
      logic [7:0] value;
      bit         typed;
      logic       body;
   } row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       push = 1'b0;
   logic       pop = 1'b0;
   logic [7:0] req_in_byte = 8'h00;
   logic       full;
   logic       empty;
   logic [7:0] rsp_out_byte;
   logic       rsp_is_body;
   logic       rsp_header_end;
   logic       rsp_last_of_run;

   parse_state_type parse_st = '{MODE_COPY, 1'b0};
   beat_type        normalized_q [$];
   int              mismatch_count = 0;
   int              beats_seen = 0;
   int              stall_cycles = 0;

   // typed rows echo the byte as a single beat
   row_type header_rows [14] = '{
      '{8'h41, 1'b1, 1'b0}, '{8'h00, 1'b1, 1'b0}, '{8'hFF, 1'b1, 1'b0},
      '{CH_CR, 1'b0, 1'b0}, '{CH_LF, 1'b0, 1'b0}, '{8'h78, 1'b0, 1'b0},
      '{CH_CR, 1'b0, 1'b0}, '{8'h79, 1'b0, 1'b0}, '{CH_LF, 1'b0, 1'b0},
      '{CH_SP, 1'b0, 1'b0}, '{8'h7A, 1'b0, 1'b0}, '{CH_LF, 1'b0, 1'b0},
      '{CH_TAB, 1'b0, 1'b0}, '{8'h3A, 1'b1, 1'b0}
   };

   row_type tail_rows [10] = '{
      '{8'h61, 1'b0, 1'b0}, '{CH_CR, 1'b0, 1'b0}, '{CH_CR, 1'b0, 1'b0},
      '{8'h62, 1'b0, 1'b0}, '{CH_CR, 1'b1, 1'b1}, '{CH_LF, 1'b1, 1'b1},
      '{CH_SP, 1'b1, 1'b1}, '{CH_TAB, 1'b1, 1'b1}, '{8'h00, 1'b1, 1'b1},
      '{8'hFF, 1'b1, 1'b1}
   };

   http_header_line_normalizer dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_in_byte     (req_in_byte),
      .empty           (empty),
      .pop             (pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_is_body     (rsp_is_body),
      .rsp_header_end  (rsp_header_end),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always begin
      #6;
      clock = 1'b1;
      #6;
      clock = 1'b0;
   end

   function automatic int fold_header_byte(input logic [7:0] ch, inout parse_state_type st,
                                           output beat_type beats [2]);
      int  n;
      int  pass;
      bit  more;
      n = 0;
      more = 1'b1;
      beats[0] = '0;
      beats[1] = '0;
      for (pass = 0; more && pass < 4; pass++) begin
         case (st.mode)
            MODE_COPY: begin
               more = 1'b0;
               if (ch == CH_CR) begin
                  st.mode = MODE_AFTER_CR;
               end else if (ch == CH_LF) begin
                  if (st.after_newline) begin
                     beats[n] = '{CH_LF, 1'b0, 1'b1, 1'b0};
                     n++;
                     st.mode = MODE_BODY;
                  end else begin
                     st.mode = MODE_AFTER_NL;
                     st.after_newline = 1'b1;
                  end
               end else begin
                  beats[n] = '{ch, 1'b0, 1'b0, 1'b0};
                  n++;
                  st.after_newline = 1'b0;
               end
            end
            MODE_AFTER_CR: begin
               if (ch == CH_LF) more = 1'b0;
               if (st.after_newline) begin
                  beats[n] = '{CH_LF, 1'b0, 1'b1, 1'b0};
                  n++;
                  st.mode = MODE_BODY;
               end else begin
                  st.mode = MODE_AFTER_NL;
                  st.after_newline = 1'b1;
               end
            end
            MODE_AFTER_NL: begin
               if (ch == CH_SP || ch == CH_TAB) begin
                  beats[n] = '{CH_SP, 1'b0, 1'b0, 1'b0};
                  n++;
                  st.after_newline = 1'b0;
                  more = 1'b0;
               end else begin
                  beats[n] = '{CH_LF, 1'b0, 1'b0, 1'b0};
                  n++;
               end
               st.mode = MODE_COPY;
            end
            default: begin
               beats[n] = '{ch, 1'b1, 1'b0, 1'b0};
               n++;
               more = 1'b0;
            end
         endcase
      end
      if (n > 0) beats[n-1].last_of_run = 1'b1;
      return n;
   endfunction

   // keep the header open: drop any byte that would end it or arm its end
   function automatic logic [7:0] pick_header_byte(input logic [7:0] prev);
      int              roll;
      logic [7:0]      ch;
      parse_state_type trial;
      beat_type        scratch [2];
      roll = $urandom_range(0, 99);
      if (prev == CH_CR && roll < 70) begin
         ch = CH_LF;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 55)      ch = 8'($urandom_range(8'h21, 8'h7E));
         else if (roll < 63) ch = 8'($urandom_range(0, 255));
         else if (roll < 73) ch = CH_CR;
         else if (roll < 83) ch = CH_LF;
         else if (roll < 91) ch = CH_SP;
         else                ch = CH_TAB;
      end
      trial = parse_st;
      void'(fold_header_byte(ch, trial, scratch));
      if (trial.mode == MODE_BODY || (trial.mode == MODE_AFTER_CR && trial.after_newline))
         ch = 8'h61 + 8'($urandom_range(0, 25));
      return ch;
   endfunction

   function automatic logic [7:0] pick_body_byte();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70)      return 8'($urandom_range(0, 255));
      else if (roll < 80) return CH_CR;
      else if (roll < 90) return CH_LF;
      else if (roll < 95) return CH_SP;
      else                return CH_TAB;
   endfunction

   task automatic send_byte(input logic [7:0] value, input bit typed, input logic body,
                            input bit may_idle);
      int       n;
      int       k;
      beat_type beats [2];
      beat_type echo;
      while (may_idle && $urandom_range(0, 99) < 16) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_in_byte <= value;
      @(posedge clock);
      while (full) @(posedge clock);
      n = fold_header_byte(value, parse_st, beats);
      if (typed) begin
         echo = '{value, body, 1'b0, 1'b1};
         normalized_q.push_back(echo);
      end else begin
         for (k = 0; k < n; k++) normalized_q.push_back(beats[k]);
      end
   endtask

   initial begin
      int         i;
      bit         drained;
      logic [7:0] ch;
      logic [7:0] prev;
      drained = 1'b0;
      prev = 8'h00;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (header_rows[r])
         send_byte(header_rows[r].value, header_rows[r].typed, header_rows[r].body, 1'b1);
      for (i = 0; i < HEADER_ITEMS; i++) begin
         ch = pick_header_byte(prev);
         send_byte(ch, 1'b0, 1'b0, !(i >= 200 && i < 400));
         prev = ch;
         // hold a newline back across a full drain
         if (!drained && i >= 250 && parse_st.mode == MODE_AFTER_NL) begin
            drained = 1'b1;
            push <= 1'b0;
            do @(posedge clock); while (normalized_q.size() != 0);
         end
      end
      foreach (tail_rows[r])
         send_byte(tail_rows[r].value, tail_rows[r].typed, tail_rows[r].body, 1'b1);
      for (i = 0; i < BODY_ITEMS; i++)
         send_byte(pick_body_byte(), 1'b0, 1'b0, 1'b1);
      push <= 1'b0;
      while (normalized_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      beat_type want;
      bit       held_once;
      int       hold_left;
      held_once = 1'b0;
      hold_left = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (pop && !empty) begin
            if (normalized_q.size() == 0) begin
               $error("beat %02h arrived with nothing expected", rsp_out_byte);
               mismatch_count++;
            end else begin
               want = normalized_q.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  $error("out_byte: expected %02h, got %02h", want.out_byte, rsp_out_byte);
                  mismatch_count++;
               end
               if (rsp_is_body !== want.is_body) begin
                  $error("is_body: expected %0b, got %0b", want.is_body, rsp_is_body);
                  mismatch_count++;
               end
               if (rsp_header_end !== want.header_end) begin
                  $error("header_end: expected %0b, got %0b", want.header_end,
                         rsp_header_end);
                  mismatch_count++;
               end
               if (rsp_last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %0b, got %0b", want.last_of_run,
                         rsp_last_of_run);
                  mismatch_count++;
               end
            end
            beats_seen++;
            if (!held_once && beats_seen == 120) begin
               held_once = 1'b1;
               hold_left = 80;
            end
         end
         if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left--;
         end else if (beats_seen >= 400 && beats_seen < 650) begin
            pop <= 1'b1;
         end else begin
            pop <= ($urandom_range(0, 99) >= 16);
         end
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

endmodule

FILE: sim.f
+incdir+hdl
hdl/hhln_pkg.sv
hdl/hhln_front.sv
hdl/hhln_queue.sv
hdl/hhln_back.sv
hdl/http_header_line_normalizer.sv
tb/http_header_line_normalizer_tb.sv
